FILE: sv/hpk_pkg.sv
// Package for the HPACK Huffman encoder: code ROM, lengths, shared types.
// No dependencies.
package hpk_pkg;

  localparam int unsigned CodeW = 30;
  localparam logic [29:0] EosCode = 30'h3fffffff;

  // Work item handed from front to back: a code already aligned behind the
  // pending bits, with its total bit count.
  typedef struct packed {
    logic [36:0] acc;    // pending bits followed by code
    logic [5:0]  total;  // valid bits in acc (<= 37)
    logic        last;
  } hpk_work_t;

  function automatic logic [29:0] code_lut(input logic [7:0] s);
    logic [29:0] c;
    unique case (s)
      8'd0: c = 30'h1ff8; 8'd1: c = 30'h7fffd8; 8'd2: c = 30'hfffffe2; 8'd3: c = 30'hfffffe3;
      8'd4: c = 30'hfffffe4; 8'd5: c = 30'hfffffe5; 8'd6: c = 30'hfffffe6; 8'd7: c = 30'hfffffe7;
      8'd8: c = 30'hfffffe8; 8'd9: c = 30'hffffea; 8'd10: c = 30'h3ffffffc; 8'd11: c = 30'hfffffe9;
      8'd12: c = 30'hfffffea; 8'd13: c = 30'h3ffffffd; 8'd14: c = 30'hfffffeb; 8'd15: c = 30'hfffffec;
      8'd16: c = 30'hfffffed; 8'd17: c = 30'hfffffee; 8'd18: c = 30'hfffffef; 8'd19: c = 30'hffffff0;
      8'd20: c = 30'hffffff1; 8'd21: c = 30'hffffff2; 8'd22: c = 30'h3ffffffe; 8'd23: c = 30'hffffff3;
      8'd24: c = 30'hffffff4; 8'd25: c = 30'hffffff5; 8'd26: c = 30'hffffff6; 8'd27: c = 30'hffffff7;
      8'd28: c = 30'hffffff8; 8'd29: c = 30'hffffff9; 8'd30: c = 30'hffffffa; 8'd31: c = 30'hffffffb;
      8'd32: c = 30'h14; 8'd33: c = 30'h3f8; 8'd34: c = 30'h3f9; 8'd35: c = 30'hffa;
      8'd36: c = 30'h1ff9; 8'd37: c = 30'h15; 8'd38: c = 30'hf8; 8'd39: c = 30'h7fa;
      8'd40: c = 30'h3fa; 8'd41: c = 30'h3fb; 8'd42: c = 30'hf9; 8'd43: c = 30'h7fb;
      8'd44: c = 30'hfa; 8'd45: c = 30'h16; 8'd46: c = 30'h17; 8'd47: c = 30'h18;
      8'd48: c = 30'h0; 8'd49: c = 30'h1; 8'd50: c = 30'h2; 8'd51: c = 30'h19;
      8'd52: c = 30'h1a; 8'd53: c = 30'h1b; 8'd54: c = 30'h1c; 8'd55: c = 30'h1d;
      8'd56: c = 30'h1e; 8'd57: c = 30'h1f; 8'd58: c = 30'h5c; 8'd59: c = 30'hfb;
      8'd60: c = 30'h7ffc; 8'd61: c = 30'h20; 8'd62: c = 30'hffb; 8'd63: c = 30'h3fc;
      8'd64: c = 30'h1ffa; 8'd65: c = 30'h21; 8'd66: c = 30'h5d; 8'd67: c = 30'h5e;
      8'd68: c = 30'h5f; 8'd69: c = 30'h60; 8'd70: c = 30'h61; 8'd71: c = 30'h62;
      8'd72: c = 30'h63; 8'd73: c = 30'h64; 8'd74: c = 30'h65; 8'd75: c = 30'h66;
      8'd76: c = 30'h67; 8'd77: c = 30'h68; 8'd78: c = 30'h69; 8'd79: c = 30'h6a;
      8'd80: c = 30'h6b; 8'd81: c = 30'h6c; 8'd82: c = 30'h6d; 8'd83: c = 30'h6e;
      8'd84: c = 30'h6f; 8'd85: c = 30'h70; 8'd86: c = 30'h71; 8'd87: c = 30'h72;
      8'd88: c = 30'hfc; 8'd89: c = 30'h73; 8'd90: c = 30'hfd; 8'd91: c = 30'h1ffb;
      8'd92: c = 30'h7fff0; 8'd93: c = 30'h1ffc; 8'd94: c = 30'h3ffc; 8'd95: c = 30'h22;
      8'd96: c = 30'h7ffd; 8'd97: c = 30'h3; 8'd98: c = 30'h23; 8'd99: c = 30'h4;
      8'd100: c = 30'h24; 8'd101: c = 30'h5; 8'd102: c = 30'h25; 8'd103: c = 30'h26;
      8'd104: c = 30'h27; 8'd105: c = 30'h6; 8'd106: c = 30'h74; 8'd107: c = 30'h75;
      8'd108: c = 30'h28; 8'd109: c = 30'h29; 8'd110: c = 30'h2a; 8'd111: c = 30'h7;
      8'd112: c = 30'h2b; 8'd113: c = 30'h76; 8'd114: c = 30'h2c; 8'd115: c = 30'h8;
      8'd116: c = 30'h9; 8'd117: c = 30'h2d; 8'd118: c = 30'h77; 8'd119: c = 30'h78;
      8'd120: c = 30'h79; 8'd121: c = 30'h7a; 8'd122: c = 30'h7b; 8'd123: c = 30'h7ffe;
      8'd124: c = 30'h7fc; 8'd125: c = 30'h3ffd; 8'd126: c = 30'h1ffd; 8'd127: c = 30'hffffffc;
      8'd128: c = 30'hfffe6; 8'd129: c = 30'h3fffd2; 8'd130: c = 30'hfffe7; 8'd131: c = 30'hfffe8;
      8'd132: c = 30'h3fffd3; 8'd133: c = 30'h3fffd4; 8'd134: c = 30'h3fffd5; 8'd135: c = 30'h7fffd9;
      8'd136: c = 30'h3fffd6; 8'd137: c = 30'h7fffda; 8'd138: c = 30'h7fffdb; 8'd139: c = 30'h7fffdc;
      8'd140: c = 30'h7fffdd; 8'd141: c = 30'h7fffde; 8'd142: c = 30'hffffeb; 8'd143: c = 30'h7fffdf;
      8'd144: c = 30'hffffec; 8'd145: c = 30'hffffed; 8'd146: c = 30'h3fffd7; 8'd147: c = 30'h7fffe0;
      8'd148: c = 30'hffffee; 8'd149: c = 30'h7fffe1; 8'd150: c = 30'h7fffe2; 8'd151: c = 30'h7fffe3;
      8'd152: c = 30'h7fffe4; 8'd153: c = 30'h1fffdc; 8'd154: c = 30'h3fffd8; 8'd155: c = 30'h7fffe5;
      8'd156: c = 30'h3fffd9; 8'd157: c = 30'h7fffe6; 8'd158: c = 30'h7fffe7; 8'd159: c = 30'hffffef;
      8'd160: c = 30'h3fffda; 8'd161: c = 30'h1fffdd; 8'd162: c = 30'hfffe9; 8'd163: c = 30'h3fffdb;
      8'd164: c = 30'h3fffdc; 8'd165: c = 30'h7fffe8; 8'd166: c = 30'h7fffe9; 8'd167: c = 30'h1fffde;
      8'd168: c = 30'h7fffea; 8'd169: c = 30'h3fffdd; 8'd170: c = 30'h3fffde; 8'd171: c = 30'hfffff0;
      8'd172: c = 30'h1fffdf; 8'd173: c = 30'h3fffdf; 8'd174: c = 30'h7fffeb; 8'd175: c = 30'h7fffec;
      8'd176: c = 30'h1fffe0; 8'd177: c = 30'h1fffe1; 8'd178: c = 30'h3fffe0; 8'd179: c = 30'h1fffe2;
      8'd180: c = 30'h7fffed; 8'd181: c = 30'h3fffe1; 8'd182: c = 30'h7fffee; 8'd183: c = 30'h7fffef;
      8'd184: c = 30'hfffea; 8'd185: c = 30'h3fffe2; 8'd186: c = 30'h3fffe3; 8'd187: c = 30'h3fffe4;
      8'd188: c = 30'h7ffff0; 8'd189: c = 30'h3fffe5; 8'd190: c = 30'h3fffe6; 8'd191: c = 30'h7ffff1;
      8'd192: c = 30'h3ffffe0; 8'd193: c = 30'h3ffffe1; 8'd194: c = 30'hfffeb; 8'd195: c = 30'h7fff1;
      8'd196: c = 30'h3fffe7; 8'd197: c = 30'h7ffff2; 8'd198: c = 30'h3fffe8; 8'd199: c = 30'h1ffffec;
      8'd200: c = 30'h3ffffe2; 8'd201: c = 30'h3ffffe3; 8'd202: c = 30'h3ffffe4; 8'd203: c = 30'h7ffffde;
      8'd204: c = 30'h7ffffdf; 8'd205: c = 30'h3ffffe5; 8'd206: c = 30'hfffff1; 8'd207: c = 30'h1ffffed;
      8'd208: c = 30'h7fff2; 8'd209: c = 30'h1fffe3; 8'd210: c = 30'h3ffffe6; 8'd211: c = 30'h7ffffe0;
      8'd212: c = 30'h7ffffe1; 8'd213: c = 30'h3ffffe7; 8'd214: c = 30'h7ffffe2; 8'd215: c = 30'hfffff2;
      8'd216: c = 30'h1fffe4; 8'd217: c = 30'h1fffe5; 8'd218: c = 30'h3ffffe8; 8'd219: c = 30'h3ffffe9;
      8'd220: c = 30'hffffffd; 8'd221: c = 30'h7ffffe3; 8'd222: c = 30'h7ffffe4; 8'd223: c = 30'h7ffffe5;
      8'd224: c = 30'hfffec; 8'd225: c = 30'hfffff3; 8'd226: c = 30'hfffed; 8'd227: c = 30'h1fffe6;
      8'd228: c = 30'h3fffe9; 8'd229: c = 30'h1fffe7; 8'd230: c = 30'h1fffe8; 8'd231: c = 30'h7ffff3;
      8'd232: c = 30'h3fffea; 8'd233: c = 30'h3fffeb; 8'd234: c = 30'h1ffffee; 8'd235: c = 30'h1ffffef;
      8'd236: c = 30'hfffff4; 8'd237: c = 30'hfffff5; 8'd238: c = 30'h3ffffea; 8'd239: c = 30'h7ffff4;
      8'd240: c = 30'h3ffffeb; 8'd241: c = 30'h7ffffe6; 8'd242: c = 30'h3ffffec; 8'd243: c = 30'h3ffffed;
      8'd244: c = 30'h7ffffe7; 8'd245: c = 30'h7ffffe8; 8'd246: c = 30'h7ffffe9; 8'd247: c = 30'h7ffffea;
      8'd248: c = 30'h7ffffeb; 8'd249: c = 30'hffffffe; 8'd250: c = 30'h7ffffec; 8'd251: c = 30'h7ffffed;
      8'd252: c = 30'h7ffffee; 8'd253: c = 30'h7ffffef; 8'd254: c = 30'h7fffff0; 8'd255: c = 30'h3ffffee;
      default: c = 30'h0;
    endcase
    return c;
  endfunction

  localparam logic [4:0] LenRom [256] = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
  };

endpackage

FILE: sv/hpk_front.sv
// Front end: code lookup and bit accounting; tracks the leftover bits.
// Depends on hpk_pkg.
module hpk_front import hpk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] prefix_bits_q_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       work_valid_o,
  input  logic       work_ready_i,
  output hpk_work_t  work_o
);

  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic       start_q, start_d;
  logic [6:0] pb;
  logic [2:0] pc;
  logic [4:0] len;
  logic [5:0] total;
  logic [36:0] acc;
  logic       fire;

  assign ready_o = work_ready_i;
  assign work_valid_o = valid_i;
  assign fire = valid_i && work_ready_i;

  always_comb begin
    pb  = start_q ? 7'd0 : pend_bits_q;
    pc  = start_q ? prefix_bits_q_i : pend_cnt_q;
    len = LenRom[symbol_i];
    acc = ({30'd0, pb} << len) | {7'd0, code_lut(symbol_i)};
    total = {3'd0, pc} + {1'd0, len};
    work_o.acc = acc;
    work_o.total = total;
    work_o.last = last_i;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    start_d     = start_q;
    if (fire) begin
      if (last_i) begin
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        start_d     = 1'b1;
      end else begin
        // low total%8 bits of acc stay pending
        pend_bits_d = acc[6:0] & ((7'd1 << total[2:0]) - 7'd1);
        pend_cnt_d  = total[2:0];
        start_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      start_q     <= 1'b1;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      start_q     <= start_d;
    end
  end

endmodule

FILE: sv/hpk_fifo.sv
// Two-entry queue between front and back end.
// Depends on hpk_pkg.
module hpk_fifo import hpk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hpk_work_t in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hpk_work_t out_o
);

  hpk_work_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/hpk_back.sv
// Back end: emits whole bytes of one work item, one per cycle while ready_i is high, with padding on the last item.
// Depends on hpk_pkg.
module hpk_back import hpk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       work_valid_i,
  output logic       work_ready_o,
  input  hpk_work_t  work_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  // Remaining bits; on last the total is rounded up with ones padding.
  logic [5:0]  rem;
  logic [5:0]  cnt_q, cnt_d;   // bits already consumed of the current item
  logic [43:0] padded;
  logic [2:0]  pad;
  logic [5:0]  top;            // total rounded up to a byte boundary
  logic [29:0] eos_sh;
  logic [5:0]  full;
  logic [5:0]  nxt;
  logic        done;
  logic        has_byte;
  logic [43:0] sh;

  always_comb begin
    pad  = 3'd0 - work_i.total[2:0];
    top  = work_i.total + {3'd0, pad};
    full = work_i.last ? top : {work_i.total[5:3], 3'b000};
    // leading bits of EOS fill the pad
    eos_sh = EosCode >> (5'(CodeW) - {2'd0, pad});
    padded = ({7'd0, work_i.acc} << pad) | {14'd0, eos_sh};
    rem  = full - cnt_q;
    has_byte = rem != 6'd0;
    nxt = cnt_q + 6'd8;
    sh = padded >> (top - nxt);
    done = !has_byte || (rem == 6'd8 && ready_i);
    valid_o = work_valid_i && has_byte;
    out_byte_o = sh[7:0];
    last_byte_o = work_i.last && rem == 6'd8;
    work_ready_o = work_valid_i && done;
    cnt_d = cnt_q;
    if (work_valid_i) begin
      if (done) cnt_d = '0;
      else if (ready_i) cnt_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

endmodule

FILE: sv/hpack_huffman_encoder_top.sv
// HPACK Huffman encoder top level: one string byte in, encoded bytes out.
// Depends on hpk_pkg, hpk_front, hpk_fifo, hpk_back.
// One symbol is accepted per cycle while the output keeps up; each symbol
// yields 0 to 5 bytes, sent one per cycle by the back end while the
// receiver is ready. A two-entry queue sits between the lookup front end
// and the byte emitter. prefix_bits is sampled at string start.
module hpack_huffman_encoder_top import hpk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  logic [2:0] prefix_bits_q;
  hpk_work_t  fw, bw;
  logic       fv, fr, bv, br;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prefix_bits_q <= '0;
    else if (cfg_we_i) prefix_bits_q <= cfg_wdata_i;
  end

  hpk_front u_front (.clk_i, .rst_ni, .prefix_bits_q_i(prefix_bits_q),
    .valid_i(in_valid_i), .ready_o(in_ready_o), .symbol_i, .last_i,
    .work_valid_o(fv), .work_ready_i(fr), .work_o(fw));

  hpk_fifo u_fifo (.clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_i(fw),
    .out_valid_o(bv), .out_ready_i(br), .out_o(bw));

  hpk_back u_back (.clk_i, .rst_ni, .work_valid_i(bv), .work_ready_o(br),
    .work_i(bw), .valid_o(out_valid_o), .ready_i(out_ready_i),
    .out_byte_o, .last_byte_o);

endmodule

FILE: dv/testbench.sv
// Testbench for hpack_huffman_encoder_top: directed and random strings,
// checked byte by byte against an in-bench HPACK Huffman encoder.
// Depends on hpk_pkg (types only) and the encoder RTL.
`timescale 1ns / 100ps

module testbench;
  import hpk_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } enc_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] symbol_i = '0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_byte_o;

  // encoder shadow state
  logic [2:0] prefix_reg;
  logic [6:0] carry_bits;
  logic [2:0] carry_cnt;
  logic       new_string;

  enc_byte_t  expected_bytes[$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         rx_jitter = 1'b1;
  bit         tx_jitter = 1'b1;
  int         hold_off = 0;
  int         hold_reqs = 0;   // bumped by the test to ask for a long hold-off
  int         hold_seen = 0;

  logic [29:0] huff_code [256];
  int          huff_len [256];

  always #6 clk_i = ~clk_i;

  hpack_huffman_encoder_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .symbol_i, .last_i, .out_valid_o, .out_ready_i, .out_byte_o, .last_byte_o
  );

  initial begin
    huff_code = '{
      30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
      30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,
      30'h3ffffffd,30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,
      30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,
      30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,
      30'hffffffb,30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
      30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,30'h0,30'h1,30'h2,
      30'h19,30'h1a,30'h1b,30'h1c,30'h1d,30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,
      30'hffb,30'h3fc,30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
      30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,30'h6b,30'h6c,30'h6d,
      30'h6e,30'h6f,30'h70,30'h71,30'h72,30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,
      30'h1ffc,30'h3ffc,30'h22,30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,
      30'h26,30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,30'h2b,30'h76,
      30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,
      30'h3ffd,30'h1ffd,30'hffffffc,30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,
      30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,30'h3fffd6,30'h7fffda,30'h7fffdb,
      30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,30'hffffec,30'hffffed,
      30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,30'h7fffe4,
      30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
      30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,
      30'h1fffde,30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,
      30'h7fffeb,30'h7fffec,30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,
      30'h3fffe1,30'h7fffee,30'h7fffef,30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,
      30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,30'h3ffffe0,30'h3ffffe1,30'hfffeb,
      30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,30'h3ffffe2,30'h3ffffe3,
      30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,30'h1ffffed,30'h7fff2,
      30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,30'hfffff2,
      30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
      30'h7ffffe5,30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,
      30'h1fffe8,30'h7ffff3,30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,
      30'hfffff5,30'h3ffffea,30'h7ffff4,30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,
      30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,30'h7ffffea,30'h7ffffeb,30'hffffffe,
      30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,30'h3ffffee};
    huff_len = '{
      13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
      28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
      6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
      5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
      13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
      7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
      15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
      6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
      20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
      24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
      22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
      21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
      26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
      19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
      20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
      26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
  end

  // Appends the bytes that one symbol completes to expected_bytes.
  function automatic void encode_symbol(input logic [7:0] sym, input logic fin);
    logic [36:0] acc;
    int          nbits;
    int          first;
    int          pad;
    enc_byte_t   b;
    first = expected_bytes.size();
    if (new_string) begin
      carry_bits = '0;
      carry_cnt  = prefix_reg;
      new_string = 1'b0;
    end
    acc   = (37'(carry_bits) << huff_len[sym]) | 37'(huff_code[sym]);
    nbits = carry_cnt + huff_len[sym];
    while (nbits >= 8) begin
      nbits -= 8;
      b.data = 8'(acc >> nbits);
      b.fin  = 1'b0;
      expected_bytes.push_back(b);
    end
    if (fin) begin
      if (nbits > 0) begin
        pad    = 8 - nbits;
        // EOS prefix is all ones
        b.data = 8'((acc << pad) | ((37'd1 << pad) - 1));
        b.fin  = 1'b0;
        expected_bytes.push_back(b);
      end
      if (expected_bytes.size() > first)
        expected_bytes[expected_bytes.size() - 1].fin = 1'b1;
      carry_bits = '0;
      carry_cnt  = '0;
      new_string = 1'b1;
    end else begin
      carry_bits = 7'(acc & ((37'd1 << nbits) - 1));
      carry_cnt  = 3'(nbits);
    end
  endfunction

  // Valid stays high after a transfer until the next item or an idle gap
  // replaces it, so each edge sees at most one update of in_valid_i.
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    int gap;
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    last_i     <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_symbol(sym, fin);
  endtask

  task automatic send_string(input int n, input bit short_codes);
    logic [7:0] s;
    for (int i = 0; i < n; i++) begin
      s = short_codes ? 8'($urandom_range(32, 126)) : 8'($urandom);
      send_symbol(s, i == n - 1);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_prefix(input logic [2:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    prefix_reg  = v;
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_off    <= 80;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      hold_off    <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    enc_byte_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, actual %h last %b", $time, out_byte_o, last_byte_o);
        errors++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_byte_o !== exp_b.data || last_byte_o !== exp_b.fin) begin
          $display("%0t: byte mismatch, expected %h/%b actual %h/%b", $time,
                   exp_b.data, exp_b.fin, out_byte_o, last_byte_o);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("[hpack_huffman_encoder_top] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    // single short symbol, extremes of the symbol range, longest codes
    send_symbol(8'd48, 1'b1);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd10, 1'b0);
    send_symbol(8'd13, 1'b0);
    send_symbol(8'd22, 1'b1);
    // exact byte boundary on last: 'X' is 8 bits
    send_symbol(8'd88, 1'b1);
    // 5+5+6 bits = 16, boundary after three short symbols
    send_symbol(8'd48, 1'b0);
    send_symbol(8'd49, 1'b0);
    send_symbol(8'd32, 1'b1);
    send_symbol(8'd127, 1'b0);
    send_symbol(8'd128, 1'b1);
  endtask

  task automatic test_prefix_settings();
    logic [2:0] vals [4] = '{3'd7, 3'd3, 3'd1, 3'd5};
    foreach (vals[k]) begin
      write_prefix(vals[k]);
      send_symbol(8'd10, 1'b1);        // 30 + prefix: up to 5 bytes
      send_symbol(8'd48, 1'b1);
      send_string(3, 1'b1);
    end
    // write during a string takes effect at the next one
    send_symbol(8'd97, 1'b0);
    write_prefix(3'd2);
    send_symbol(8'd98, 1'b1);
    send_string(2, 1'b0);
  endtask

  task automatic test_random();
    int n;
    for (int s = 0; s < 20; s++) begin
      if (s % 5 == 4) write_prefix(3'($urandom));
      n = $urandom_range(1, 6);
      send_string(n, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_backpressure();
    hold_reqs = hold_reqs + 1;
    send_string(12, 1'b0);
  endtask

  task automatic test_full_rate();
    drain();
    rx_jitter = 1'b0;
    tx_jitter = 1'b0;
    write_prefix(3'd0);
    send_string(10, 1'b1);
  endtask

  initial begin
    prefix_reg = '0;
    carry_bits = '0;
    carry_cnt  = '0;
    new_string = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_prefix_settings();
    test_random();
    test_backpressure();
    test_full_rate();
    drain();
    if (errors == 0 && expected_bytes.size() == 0)
      $display("[hpack_huffman_encoder_top] OK");
    else
      $display("[hpack_huffman_encoder_top] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/hpk_pkg.sv
sv/hpk_front.sv
sv/hpk_fifo.sv
sv/hpk_back.sv
sv/hpack_huffman_encoder_top.sv
dv/testbench.sv
